[design/ppie_pkg.sv]
// Shared constants, types and state encoding for the pulse peak interval estimator.
`default_nettype none
package ppie_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SUM_W       = 27;
  localparam int WCNT_W      = 6;
  localparam int PROD_W      = SUM_W + WCNT_W + 1;
  localparam int DIVD_W      = 30;
  localparam int DIVS_W      = ADDR_W;
  localparam int HW_W        = 5;
  localparam int SP_W        = 4;
  localparam int MD_W        = 8;
  localparam int PER_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int SPC_W       = 24;
  localparam int IVL_W       = 36;
  localparam int PKC_W       = 17;
  localparam int OUT_DATA_W  = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SPAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DIST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PER   = 2'd3;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [WCNT_W-1:0] wcnt_t;

  // Operand pair for the cross-multiply comparator.
  typedef struct packed {
    sum_t  a_sum;
    wcnt_t a_cnt;
    sum_t  b_sum;
    wcnt_t b_cnt;
  } cmp_ops_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT_RD, ST_INIT_ACC, ST_SM_WR, ST_SM_RD, ST_SM_UPD,
    ST_PK_START, ST_PK_RD, ST_PK_MUL, ST_PK_CMP,
    ST_GR_RD, ST_GR_MUL, ST_GR_CMP, ST_FLUSH, ST_MUL, ST_DIV1, ST_DIV2, ST_DONE
  } state_t;
endpackage
`default_nettype wire

[design/ppie_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ppie_div (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire [ppie_pkg::DIVD_W-1:0]     dividend,
  input  wire [ppie_pkg::DIVS_W-1:0]     divisor,
  output logic                           done,
  output logic [ppie_pkg::DIVD_W-1:0]    quotient
);
  import ppie_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W:0]   rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   rem_sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DIVS_W-1:0], quo_r[DIVD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

[design/ppie_cmp.sv]
// Cross-multiply comparator: registered products, then a signed compare.
`default_nettype none
module ppie_cmp (
  input  wire                      clk,
  input  wire ppie_pkg::cmp_ops_t  ops,
  output logic                     a_less
);
  import ppie_pkg::*;

  logic signed [PROD_W-1:0] lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    lhs_r <= PROD_W'($signed(ops.a_sum) * $signed({1'b0, ops.b_cnt}));
    rhs_r <= PROD_W'($signed(ops.b_sum) * $signed({1'b0, ops.a_cnt}));
  end

  // a/ca < b/cb with positive counts
  assign a_less = lhs_r < rhs_r;
endmodule
`default_nettype wire

[design/pulse_peak_interval_estimator.sv]
// Top level: sample capture, smoothing, peak search and interval computation.
// Samples are taken one per cycle while in_tready is high; the transaction
// with in_tlast starts analysis, which uses a single shared comparator for peak
// search and group merging and a single shared divider for both divisions.
// in_tready stays low during analysis; one result transaction per record.
// rst_n (synchronous) clears control state and restores register defaults.
`default_nettype none
module pulse_peak_interval_estimator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [15:0]                          in_tdata,   // sample[15:0]
  input  wire                                  in_tlast,   // last_sample
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // spacing_q8[23:0], interval_us[59:24], peak_count[76:60], zero pad
  output logic [ppie_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser,  // status
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [ppie_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ppie_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ppie_pkg::*;

  localparam int XW = CNT_W + 1;

  state_t state_r, state_nxt;

  // configuration
  logic [HW_W-1:0]  hw_r;
  logic [SP_W-1:0]  sp_r;
  logic [MD_W-1:0]  md_r;
  logic [PER_W-1:0] per_r;

  // memories
  logic [SAMPLE_BITS-1:0]  samp_mem [MAX_SAMPLES];
  logic [WCNT_W+SUM_W-1:0] smth_mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0]  samp_a_r, samp_b_r;
  logic [WCNT_W+SUM_W-1:0] smth_a_r, smth_b_r;
  logic [ADDR_W-1:0]       samp_addr_a, samp_addr_b, smth_addr_a, smth_addr_b;

  // sequencer datapath
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  sum_t              sum_r, sum_nxt;
  logic              ok_r, ok_nxt;
  logic              open_r, open_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt, best_r, best_nxt;
  logic [ADDR_W-1:0] first_r, first_nxt, last_r, last_nxt;
  logic [CNT_W-1:0]  kept_r, kept_nxt;
  logic [DIVD_W-1:0] prod_r, prod_nxt;
  logic [SPC_W-1:0]  spc_r, spc_nxt;
  logic [IVL_W-1:0]  ivl_r, ivl_nxt;

  // output holding register
  logic                  ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;
  logic                  ou_r, ou_nxt;

  logic [XW-1:0]   ix, hx, cx, lo, hi, ahi, add_idx;
  wcnt_t           wcnt;
  logic            add_ok, sub_ok, cur_ok, near;
  logic            smth_we, samp_we, out_free;
  logic            a_less, div_start, div_done;
  logic [DIVD_W-1:0] div_quo, div_dvd;
  logic [ADDR_W-1:0] span;
  cmp_ops_t        ops;

  assign ix      = XW'(i_r);
  assign hx      = XW'(hw_r);
  assign cx      = XW'(loaded_r);
  assign add_idx = ix + hx + XW'(1);
  assign add_ok  = add_idx < cx;
  assign sub_ok  = ix >= hx;
  assign lo      = sub_ok ? ix - hx : '0;
  assign ahi     = ix + hx;
  assign hi      = (ahi > cx - XW'(1)) ? cx - XW'(1) : ahi;
  assign wcnt    = WCNT_W'(hi - lo + XW'(1));
  assign span    = last_r - first_r;
  assign near    = open_r && (ADDR_W'(i_r[ADDR_W-1:0] - start_r) < ADDR_W'(md_r));
  assign cur_ok  = ok_r && !((j_r != i_r) && a_less);
  assign out_free = !ov_r || out_tready;

  assign samp_addr_a = (state_r == ST_INIT_RD) ? j_r[ADDR_W-1:0] : add_idx[ADDR_W-1:0];
  assign samp_addr_b = ADDR_W'(ix - hx);
  assign smth_addr_a = (state_r == ST_GR_RD) ? best_r : i_r[ADDR_W-1:0];
  assign smth_addr_b = (state_r == ST_GR_RD) ? i_r[ADDR_W-1:0] : j_r[ADDR_W-1:0];

  assign samp_we = (state_r == ST_LOAD) && in_tvalid && (loaded_r < CNT_W'(MAX_SAMPLES));
  assign smth_we = (state_r == ST_SM_WR);

  // Memories: one write port, two registered read ports each.
  always_ff @(posedge clk) begin
    if (samp_we) samp_mem[loaded_r[ADDR_W-1:0]] <= in_tdata;
    samp_a_r <= samp_mem[samp_addr_a];
    samp_b_r <= samp_mem[samp_addr_b];
  end

  always_ff @(posedge clk) begin
    if (smth_we) smth_mem[i_r[ADDR_W-1:0]] <= {wcnt, sum_r};
    smth_a_r <= smth_mem[smth_addr_a];
    smth_b_r <= smth_mem[smth_addr_b];
  end

  assign ops.a_sum = smth_a_r[SUM_W-1:0];
  assign ops.a_cnt = smth_a_r[WCNT_W+SUM_W-1:SUM_W];
  assign ops.b_sum = smth_b_r[SUM_W-1:0];
  assign ops.b_cnt = smth_b_r[WCNT_W+SUM_W-1:SUM_W];

  ppie_cmp u_cmp (
    .clk    (clk),
    .ops    (ops),
    .a_less (a_less)
  );

  // First division runs span*256, the second span*period.
  assign div_start = (state_r == ST_MUL) || ((state_r == ST_DIV1) && div_done);
  assign div_dvd   = (state_r == ST_MUL) ? DIVD_W'({span, 8'd0}) : prod_r;

  ppie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (ADDR_W'(kept_r - CNT_W'(1))),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_tvalid && in_tlast) state_nxt = ST_INIT_RD;
      ST_INIT_RD:  state_nxt = ST_INIT_ACC;
      ST_INIT_ACC: begin
        if (XW'(j_r) == hx || XW'(j_r) == cx - XW'(1)) state_nxt = ST_SM_WR;
        else state_nxt = ST_INIT_RD;
      end
      ST_SM_WR:    state_nxt = (ix == cx - XW'(1)) ? ST_PK_START : ST_SM_RD;
      ST_SM_RD:    state_nxt = ST_SM_UPD;
      ST_SM_UPD:   state_nxt = ST_SM_WR;
      ST_PK_START: state_nxt = (ix + XW'(sp_r) >= cx) ? ST_FLUSH : ST_PK_RD;
      ST_PK_RD:    state_nxt = ST_PK_MUL;
      ST_PK_MUL:   state_nxt = ST_PK_CMP;
      ST_PK_CMP: begin
        if (j_r != i_r + CNT_W'(sp_r)) state_nxt = ST_PK_RD;
        else if (cur_ok && near) state_nxt = ST_GR_RD;
        else state_nxt = ST_PK_START;
      end
      ST_GR_RD:    state_nxt = ST_GR_MUL;
      ST_GR_MUL:   state_nxt = ST_GR_CMP;
      ST_GR_CMP:   state_nxt = ST_PK_START;
      ST_FLUSH: begin
        if ((kept_r + CNT_W'(open_r)) < CNT_W'(2)) state_nxt = ST_DONE;
        else state_nxt = ST_MUL;
      end
      ST_MUL:      state_nxt = ST_DIV1;
      ST_DIV1:     if (div_done) state_nxt = ST_DIV2;
      ST_DIV2:     if (div_done) state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // Datapath updates.
  always_comb begin
    loaded_nxt = loaded_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    sum_nxt    = sum_r;
    ok_nxt     = ok_r;
    open_nxt   = open_r;
    start_nxt  = start_r;
    best_nxt   = best_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    kept_nxt   = kept_r;
    prod_nxt   = prod_r;
    spc_nxt    = spc_r;
    ivl_nxt    = ivl_r;
    case (state_r)
      ST_LOAD: begin
        if (samp_we) loaded_nxt = loaded_r + CNT_W'(1);
        j_nxt   = '0;
        sum_nxt = '0;
      end
      ST_INIT_ACC: begin
        sum_nxt = sum_r + SUM_W'($signed(samp_a_r));
        j_nxt   = j_r + CNT_W'(1);
        i_nxt   = '0;
      end
      ST_SM_WR: begin
        // Reset peak search state before the search starts.
        if (ix == cx - XW'(1)) begin
          i_nxt     = CNT_W'(sp_r);
          open_nxt  = 1'b0;
          kept_nxt  = '0;
          first_nxt = '0;
          last_nxt  = '0;
          start_nxt = '0;
          best_nxt  = '0;
        end
      end
      ST_SM_UPD: begin
        sum_nxt = sum_r
                + (add_ok ? SUM_W'($signed(samp_a_r)) : '0)
                - (sub_ok ? SUM_W'($signed(samp_b_r)) : '0);
        i_nxt   = i_r + CNT_W'(1);
      end
      ST_PK_START: begin
        j_nxt  = i_r - CNT_W'(sp_r);
        ok_nxt = 1'b1;
      end
      ST_PK_CMP: begin
        ok_nxt = cur_ok;
        if (j_r != i_r + CNT_W'(sp_r)) begin
          j_nxt = j_r + CNT_W'(1);
        end else if (cur_ok && !near) begin
          // Close the open group and start a new one here.
          if (open_r) begin
            if (kept_r == '0) first_nxt = best_r;
            last_nxt = best_r;
            kept_nxt = kept_r + CNT_W'(1);
          end
          open_nxt  = 1'b1;
          start_nxt = i_r[ADDR_W-1:0];
          best_nxt  = i_r[ADDR_W-1:0];
          i_nxt     = i_r + CNT_W'(1);
        end else if (!cur_ok) begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      ST_GR_CMP: begin
        if (a_less) best_nxt = i_r[ADDR_W-1:0];
        i_nxt = i_r + CNT_W'(1);
      end
      ST_FLUSH: begin
        if (open_r) begin
          if (kept_r == '0) first_nxt = best_r;
          last_nxt = best_r;
          kept_nxt = kept_r + CNT_W'(1);
        end
        open_nxt = 1'b0;
      end
      ST_MUL:  prod_nxt = DIVD_W'(span * per_r);
      ST_DIV1: if (div_done) spc_nxt = SPC_W'(div_quo);
      ST_DIV2: if (div_done) ivl_nxt = IVL_W'(div_quo);
      ST_DONE: if (out_free) loaded_nxt = '0;
      default: ;
    endcase
  end

  // Result register: load on completion, hold until taken.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    ou_nxt = ou_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    if (state_r == ST_DONE && out_free) begin
      ov_nxt = 1'b1;
      if (kept_r < CNT_W'(2)) begin
        ou_nxt = 1'b1;
        od_nxt = OUT_DATA_W'({PKC_W'(kept_r), IVL_W'(0), SPC_W'(0)});
      end else begin
        ou_nxt = 1'b0;
        od_nxt = OUT_DATA_W'({PKC_W'(kept_r), ivl_r, spc_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    sum_r   <= sum_nxt;
    ok_r    <= ok_nxt;
    start_r <= start_nxt;
    best_r  <= best_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    prod_r  <= prod_nxt;
    spc_r   <= spc_nxt;
    ivl_r   <= ivl_nxt;
    od_r    <= od_nxt;
    ou_r    <= ou_nxt;
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      loaded_r <= '0;
      open_r   <= 1'b0;
      kept_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      open_r   <= open_nxt;
      kept_r   <= kept_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Configuration registers; write taken every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r  <= HW_W'(10);
      sp_r  <= SP_W'(3);
      md_r  <= MD_W'(10);
      per_r <= PER_W'(10000);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HALF_WINDOW: hw_r  <= cfg_data[HW_W-1:0];
        CFG_PEAK_SPAN:   sp_r  <= cfg_data[SP_W-1:0];
        CFG_MERGE_DIST:  md_r  <= cfg_data[MD_W-1:0];
        CFG_SAMPLE_PER:  per_r <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past capacity");

  a_kept_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (last_r > first_r))
    else $error("kept peaks out of order");

  a_group_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PK_START && kept_r != '0) |-> open_r)
    else $error("kept peak without open group");
endmodule
`default_nettype wire

[dv/ppie_interval_checker.sv]
// Checker for the pulse peak interval estimator: mirrors registers, predicts and compares.
module ppie_interval_checker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  input  wire                                  in_tready,
  input  wire  [15:0]                          in_tdata,
  input  wire                                  in_tlast,
  input  wire                                  out_tvalid,
  input  wire                                  out_tready,
  input  wire  [ppie_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire                                  out_tuser,
  input  wire                                  cfg_valid,
  input  wire                                  cfg_ready,
  input  wire  [ppie_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ppie_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   results_seen
);
  import ppie_pkg::*;

  typedef struct packed {
    logic             status;
    logic [SPC_W-1:0] spacing_q8;
    logic [IVL_W-1:0] interval_us;
    logic [PKC_W-1:0] peak_count;
  } interval_result_t;

  logic signed [SAMPLE_BITS-1:0] record_buf [MAX_SAMPLES];
  int                            record_len;
  logic [HW_W-1:0]               half_window;
  logic [SP_W-1:0]               peak_span;
  logic [MD_W-1:0]               merge_dist;
  logic [PER_W-1:0]              period_us;
  interval_result_t              expected_q[$];

  longint avg_sum [MAX_SAMPLES];
  longint avg_cnt [MAX_SAMPLES];

  function automatic bit avg_below(int a, int b);
    return avg_sum[a] * avg_cnt[b] < avg_sum[b] * avg_cnt[a];
  endfunction

  // Smooth, search raw peaks, merge groups, then reduce to the average spacing and interval.
  function automatic interval_result_t estimate_intervals();
    interval_result_t r;
    int     lo, hi, sp, kept, first_pk, last_pk, grp_start, grp_best;
    bit     grp_open, is_peak;
    longint acc, span, den;
    kept = 0; first_pk = 0; last_pk = 0; grp_start = 0; grp_best = 0; grp_open = 0;
    sp = int'(peak_span);
    for (int i = 0; i < record_len; i++) begin
      lo = (i - int'(half_window) < 0) ? 0 : i - int'(half_window);
      hi = (i + int'(half_window) > record_len - 1) ? record_len - 1 : i + int'(half_window);
      acc = 0;
      for (int j = lo; j <= hi; j++) acc += longint'(record_buf[j]);
      avg_sum[i] = acc;
      avg_cnt[i] = hi - lo + 1;
    end
    for (int i = sp; i < record_len - sp; i++) begin
      is_peak = 1;
      for (int j = i - sp; j <= i + sp; j++)
        if (j != i && avg_below(i, j)) is_peak = 0;
      if (!is_peak) continue;
      if (grp_open && (i - grp_start) < int'(merge_dist)) begin
        if (avg_below(grp_best, i)) grp_best = i;
      end else begin
        if (grp_open) begin
          if (kept == 0) first_pk = grp_best;
          last_pk = grp_best;
          kept++;
        end
        grp_open  = 1;
        grp_start = i;
        grp_best  = i;
      end
    end
    if (grp_open) begin
      if (kept == 0) first_pk = grp_best;
      last_pk = grp_best;
      kept++;
    end
    r.peak_count = kept[PKC_W-1:0];
    if (kept < 2) begin
      r.status      = 1'b1;
      r.spacing_q8  = '0;
      r.interval_us = '0;
    end else begin
      span          = last_pk - first_pk;
      den           = kept - 1;
      r.status      = 1'b0;
      r.spacing_q8  = SPC_W'((span << 8) / den);
      r.interval_us = IVL_W'((span * longint'(period_us)) / den);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    interval_result_t got, exp_r;
    if (!rst_n) begin
      half_window  <= HW_W'(10);
      peak_span    <= SP_W'(3);
      merge_dist   <= MD_W'(10);
      period_us    <= PER_W'(10000);
      record_len   = 0;
      fail_count   = 0;
      results_seen = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HALF_WINDOW: half_window <= cfg_data[HW_W-1:0];
          CFG_PEAK_SPAN:   peak_span   <= cfg_data[SP_W-1:0];
          CFG_MERGE_DIST:  merge_dist  <= cfg_data[MD_W-1:0];
          CFG_SAMPLE_PER:  period_us   <= cfg_data[PER_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status      = out_tuser;
        got.spacing_q8  = out_tdata[23:0];
        got.interval_us = out_tdata[59:24];
        got.peak_count  = out_tdata[76:60];
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: status %0d peaks %0d",
                 got.status, got.peak_count);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status != exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_count++;
          end
          if (got.spacing_q8 != exp_r.spacing_q8) begin
            $error("spacing_q8: expected %0d, got %0d", exp_r.spacing_q8, got.spacing_q8);
            fail_count++;
          end
          if (got.interval_us != exp_r.interval_us) begin
            $error("interval_us: expected %0d, got %0d", exp_r.interval_us,
                   got.interval_us);
            fail_count++;
          end
          if (got.peak_count != exp_r.peak_count) begin
            $error("peak_count: expected %0d, got %0d", exp_r.peak_count, got.peak_count);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        // Samples past capacity are dropped, but tlast still closes the record.
        if (record_len < MAX_SAMPLES) begin
          record_buf[record_len] = in_tdata;
          record_len++;
        end
        if (in_tlast) begin
          expected_q.push_back(estimate_intervals());
          record_len = 0;
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[dv/pulse_peak_interval_estimator_tb.sv]
// Testbench top: clock, reset, stimulus phases and final verdict for the estimator.
module pulse_peak_interval_estimator_tb;
  import ppie_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;  // sample[15:0]
  logic                  in_tlast   = 1'b0; // last_sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // spacing_q8, interval_us, peak_count, pad
  logic                  out_tuser;  // status
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int  fail_count, pending, results_seen;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  logic hold_off      = 1'b0;
  int  cycle_count    = 0;
  int  items_sent     = 0;
  int  records_sent   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_peak_interval_estimator i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ppie_interval_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen
  );

  // Receiver: stall at random unless the long hold-off is in force.
  always @(posedge clk)
    out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

  // Watchdog: abort a run that stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pulse_peak_interval_estimator_tb: FAIL");
      $finish;
    end
  end

  // Offer one sample transaction, with random idle cycles ahead of it; hold
  // valid high until the handshake. Valid is lowered only on an idle cycle.
  task automatic push_sample(input logic [15:0] value, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (last) records_sent++;
  endtask

  // Write all four registers back to back; valid drops after the last one.
  task automatic write_regs(input int hw, input int sp, input int md, input int per);
    int vals [4];
    vals = '{hw, sp, md, per};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= CFG_DATA_W'(vals[r]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain outstanding results, then let the block settle back to loading.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] clip16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // One record: mostly a noisy pulse train, sometimes raw full-range noise.
  task automatic push_record(input int len);
    int per, ph, amp, base, noise;
    bit raw;
    raw   = ($urandom_range(0, 99) < 20);
    per   = $urandom_range(2, 14);
    ph    = $urandom_range(0, per - 1);
    amp   = $urandom_range(200, 40000);
    base  = $urandom_range(0, 40000) - 20000;
    noise = $urandom_range(0, 3) * $urandom_range(0, 2000);
    for (int i = 0; i < len; i++) begin
      if (raw)
        push_sample(16'($urandom), i == len - 1);
      else
        push_sample(clip16(base + ((i % per) == ph ? amp : 0)
                           + (noise ? $urandom_range(0, noise) - noise / 2 : 0)),
                    i == len - 1);
    end
  endtask

  task automatic short_records(input int item_goal, input int rec_goal);
    int items0, recs0, len;
    items0 = items_sent;
    recs0  = records_sent;
    while (items_sent - items0 < item_goal || records_sent - recs0 < rec_goal) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 28);
      push_record(len);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single extreme sample, short mixed record, alternating
    // extremes, then a flat record where every interior point is a raw peak.
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0000, 1'b1);
    for (int i = 0; i < 12; i++)
      push_sample(i[0] ? 16'h8000 : 16'h7fff, i == 11);
    for (int i = 0; i < 8; i++)
      push_sample(16'h0000, i == 7);

    // Default registers, no idling.
    short_records(80, 8);
    drain_results();

    // Smallest legal settings, sender mostly idle.
    write_regs(1, 1, 1, 1);
    send_idle_pct = 81;
    short_records(80, 8);
    drain_results();

    // Largest legal settings, receiver mostly stalled.
    write_regs(31, 8, 255, 1000000);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    short_records(80, 8);
    drain_results();

    // Out-of-range zeros: single-sample average, every point a raw peak,
    // no merging and zero period. Both sides idle.
    write_regs(0, 0, 0, 0);
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    short_records(80, 8);
    drain_results();

    // Register field maxima, then one record overrunning the store.
    write_regs(31, 15, 255, 1048575);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_record(MAX_SAMPLES + 6);
    short_records(60, 4);
    drain_results();

    // Pressure: hold the result side off for a long stretch while records
    // keep coming, so the block parks on a result and drops in_tready.
    write_regs(2, 2, 5, 4000);
    fork
      begin
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
      end
      short_records(60, 6);
    join
    drain_results();

    // Mid-range settings, sender mostly idle.
    write_regs(4, 3, 20, 10000);
    send_idle_pct = 81;
    short_records(80, 8);
    drain_results();

    $display("Sent %0d samples in %0d records over %0d register settings;",
             items_sent, records_sent, 7);
    $display("checked %0d interval results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0)
      $display("pulse_peak_interval_estimator_tb: PASS");
    else
      $display("pulse_peak_interval_estimator_tb: FAIL");
    $finish;
  end
endmodule
